[rtl/command_line_xor_deframer_core_defines.svh]
// ----------------------------------------------------------------------------
// Command line XOR deframer assertion macros
// Shared property shorthands for the checker, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_XOR_DEFRAMER_CORE_DEFINES_SVH
`define COMMAND_LINE_XOR_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define CLXD_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define CLXD_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/clxd_pkg.sv]
// ----------------------------------------------------------------------------
// Command line XOR deframer package
// Phase and event codes, character constants and the hex digit decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clxd_pkg;

  localparam int LINE_CAPACITY = 80;
  localparam int LEN_W         = 7;
  localparam int BYTE_W        = 8;
  localparam int OUT_DATA_W    = 32;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_HEX1 = 3'd2,
    PH_HEX2 = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_ACCEPT   = 3'd1,
    EV_MISMATCH = 3'd2,
    EV_EXTRA    = 3'd3,
    EV_FRAMING  = 3'd4
  } event_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h = '{valid: 1'b0, value: 4'd0};
    if (c inside {[8'h30:8'h39]}) begin
      h = '{valid: 1'b1, value: 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      h = '{valid: 1'b1, value: 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      h = '{valid: 1'b1, value: 4'(c - 8'h57)};
    end
    return h;
  endfunction

endpackage

[rtl/command_line_xor_deframer_core.sv]
// ----------------------------------------------------------------------------
// Command line XOR deframer core
// Frames '$'/'!' lines, passes body bytes on, checks the '*hh' XOR checksum.
// ----------------------------------------------------------------------------
// Output: a result word is registered and appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the output register takes a new word in the
// cycle its previous word is taken, so s_tready only drops while m_tvalid is
// held with m_tready low.
// Reset: rst clears the line state and the output valid; no clearing pass.
`timescale 1ns / 1ps

module command_line_xor_deframer_core
  import clxd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] payload_byte, [14:8] line_length, [22:15] computed_sum,
  // [30:23] received_sum, [31] sum_present
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [2:0]            m_tuser    // [2:0] event_kind
);

  phase_t            phase, phase_next;
  logic [7:0]        running_xor, running_xor_next;
  logic [7:0]        parsed_sum, parsed_sum_next;
  logic [LEN_W-1:0]  body_count, body_count_next;

  logic              emit;
  event_t            emit_kind;
  logic [7:0]        emit_payload;
  logic [LEN_W-1:0]  emit_len;
  logic [7:0]        emit_xor;
  logic              emit_present;

  logic              accept;
  logic [7:0]        c;
  hex_t              hx;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign c        = s_tdata;
  assign hx       = hex_decode(c);

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    parsed_sum_next  = parsed_sum;
    body_count_next  = body_count;
    emit             = 1'b0;
    emit_kind        = EV_FRAMING;
    emit_payload     = 8'd0;
    emit_len         = body_count;
    emit_xor         = running_xor;
    emit_present     = (phase == PH_DONE);
    if (c != CH_NUL) begin
      case (phase)
        PH_BODY, PH_HEX1, PH_HEX2, PH_DONE: begin
          if (c == CH_CR || c == CH_LF) begin
            emit             = 1'b1;
            emit_kind        = (phase == PH_DONE && running_xor != parsed_sum)
                               ? EV_MISMATCH : EV_ACCEPT;
            running_xor_next = 8'd0;
            body_count_next  = '0;
            phase_next       = PH_IDLE;
          end else if (c == CH_STAR) begin
            phase_next = PH_HEX1;
          end else if (phase == PH_HEX1 && hx.valid) begin
            parsed_sum_next = {hx.value, 4'd0};
            phase_next      = PH_HEX2;
          end else if (phase == PH_HEX2 && hx.valid) begin
            parsed_sum_next = {parsed_sum[7:4], hx.value};
            phase_next      = PH_DONE;
          end else if (phase == PH_BODY && body_count < LEN_W'(LINE_CAPACITY)) begin
            body_count_next  = body_count + LEN_W'(1);
            running_xor_next = running_xor ^ c;
            emit             = 1'b1;
            emit_kind        = EV_PAYLOAD;
            emit_payload     = c;
            emit_len         = body_count_next;
            emit_xor         = running_xor_next;
          end else if (phase == PH_DONE) begin
            emit      = 1'b1;
            emit_kind = EV_EXTRA;
          end else begin
            emit      = 1'b1;
            emit_kind = EV_FRAMING;
          end
        end
        default: begin
          phase_next = (c == CH_DOLLAR || c == CH_BANG) ? PH_BODY : PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      running_xor <= 8'd0;
      parsed_sum  <= 8'd0;
      body_count  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        running_xor <= running_xor_next;
        parsed_sum  <= parsed_sum_next;
        body_count  <= body_count_next;
      end
      if (s_tready) begin
        m_tvalid <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tdata <= {emit_present, parsed_sum, emit_xor, emit_len, emit_payload};
      m_tuser <= emit_kind;
    end
  end

endmodule

[rtl/clxd_checker.sv]
// ----------------------------------------------------------------------------
// Command line XOR deframer checker
// Port-level properties of the deframer, bound onto the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "command_line_xor_deframer_core_defines.svh"

module clxd_checker
  import clxd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [BYTE_W-1:0]     s_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [2:0]            m_tuser
);

  `CLXD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")
  `CLXD_ASSERT_IMP(a_kind_range, m_tvalid, m_tuser <= EV_FRAMING, "event kind out of range")
  `CLXD_ASSERT_IMP(a_payload_len, m_tvalid && m_tuser == EV_PAYLOAD, m_tdata[14:8] != 7'd0 && m_tdata[14:8] <= 7'(LINE_CAPACITY) && !m_tdata[31], "payload word with bad length or checksum flag")
  `CLXD_ASSERT_NXT(a_nul_silent, s_tvalid && s_tready && s_tdata == CH_NUL && (!m_tvalid || m_tready), !m_tvalid, "NUL byte produced a word")
  `CLXD_ASSERT_IMP(a_reset_empty, $past(rst), !m_tvalid, "output valid right after reset")

endmodule

bind command_line_xor_deframer_core clxd_checker u_clxd_checker (.*);
